// File: hw/rtl/chrd_pkg.sv
`default_nettype none

package chrd_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;

  localparam logic [WORD_W-1:0] SEED_RESET = 64'd1;

  // mixer constants
  localparam logic [WORD_W-1:0] LANE_A_MUL  = 64'h0000_0000_0bad_babe;
  localparam logic [WORD_W-1:0] LANE_B_MUL  = 64'h0000_00c0_07c0_ffee;
  localparam logic [WORD_W-1:0] LANE_C_MUL  = 64'h0000_0000_dead_beef;
  localparam logic [WORD_W-1:0] LOW_ADD     = 64'h0000_0000_0000_0b00;
  localparam logic [WORD_W-1:0] LOW_OFFSET  = 64'h0000_0000_0bad_d0d0;
  localparam logic [WORD_W-1:0] HIGH_OFFSET = 64'h0000_0000_0c00_7dad;

  localparam int QUEUE_DEPTH = 2;

  // six 64-bit products, each built from three 32x32 partial products
  localparam int PRODUCTS = 6;
  localparam int PROD_IDX_W = 3;

  typedef logic [PROD_IDX_W-1:0] prod_idx_t;

  typedef enum logic [1:0] {
    LANE_LO,
    LANE_MID,
    LANE_HI
  } lane_t;

  typedef enum logic [1:0] {
    RT_W0_W1,  // w0 += p >> 32, w1 += p
    RT_W0,     // w0 += p
    RT_W1_W2   // w1 += p >> 32, w2 = p + LOW_ADD
  } route_t;

  typedef enum logic [1:0] {
    PART_LL,   // a_lo * c_lo
    PART_HL,   // a_hi * c_lo, weight 2^32
    PART_LH    // a_lo * c_hi, weight 2^32
  } part_t;

  typedef enum logic [2:0] {
    MX_IDLE,
    MX_MUL,
    MX_ACC,
    MX_ROUTE,
    MX_FOLD_LO,
    MX_FOLD_HI,
    MX_DONE
  } mix_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIN
  } mod_state_t;

  // queue entry: counter value taken at accept plus the request
  typedef struct packed {
    logic [WORD_W-1:0] draw;
    logic [WORD_W-1:0] modulus;
  } qent_t;

  // mixer result handed to the reduction unit
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] modulus;
  } draw_t;

  function automatic lane_t mul_lane(input prod_idx_t idx);
    lane_t l;
    unique case (idx)
      3'd0: l = LANE_MID;
      3'd1: l = LANE_HI;
      3'd2: l = LANE_LO;
      3'd3: l = LANE_MID;
      3'd4: l = LANE_HI;
      3'd5: l = LANE_HI;
      default: l = LANE_MID;
    endcase
    return l;
  endfunction

  function automatic logic [WORD_W-1:0] mul_const(input prod_idx_t idx);
    logic [WORD_W-1:0] c;
    unique case (idx)
      3'd0: c = LANE_C_MUL;
      3'd1: c = LANE_B_MUL;
      3'd2: c = LANE_C_MUL;
      3'd3: c = LANE_B_MUL;
      3'd4: c = LANE_A_MUL;
      3'd5: c = LANE_C_MUL;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic route_t mul_route(input prod_idx_t idx);
    route_t r;
    unique case (idx)
      3'd0: r = RT_W0_W1;
      3'd1: r = RT_W0_W1;
      3'd2: r = RT_W0;
      3'd3: r = RT_W0;
      3'd4: r = RT_W0;
      3'd5: r = RT_W1_W2;
      default: r = RT_W0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/counter_hash_random_draw_top.sv
// A draw passes through the queue, the mixer and the bit-serial modulo unit,
//   whose remainder loop is skipped for a zero modulus; a result may also wait on
//   an output stall or behind earlier draws. The modulo unit (one remainder bit a
//   cycle) paces draws with a nonzero modulus, the mixer those with zero modulus.
// Reset (rst, synchronous, active high): draw counter = 1, queue empty, all units idle.
`default_nettype none

module counter_hash_random_draw_top #(
  parameter int QDEPTH = chrd_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // seed write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [chrd_pkg::WORD_W-1:0]  start_seed,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [chrd_pkg::WORD_W-1:0]  modulus,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [chrd_pkg::WORD_W-1:0]       random_value
);

  // Front: owns the draw counter. Each request transfer snapshots the
  // counter with its modulus into the queue and bumps the counter unless a
  // seed write reloads it; request order fixes each result's counter value.
  logic            push_valid;
  logic            push_ready;
  chrd_pkg::qent_t push_data;

  // Queue -> mixer
  logic            pop_valid;
  logic            pop_ready;
  chrd_pkg::qent_t pop_data;

  // Mixer -> modulo unit
  logic            mix_valid;
  logic            mix_ready;
  chrd_pkg::draw_t mix_data;

  chrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .start_seed (start_seed),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .modulus    (modulus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Short queue decoupling request intake from the back end; requests
  // keep being taken while a result waits in the output register, until the queue fills.
  chrd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Mixer: three lanes (v - offset, v, v + offset), six 64-bit wrapping
  // products on one 32x32 multiplier (three partials each), then the
  // two carry folds that build the high and low 32-bit words.
  chrd_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .res_valid (mix_valid),
    .res_ready (mix_ready),
    .res_data  (mix_data)
  );

  // Modulo: 64-step restoring remainder, bypassed for zero modulus;
  // ends in the output register that drives the result channel.
  chrd_mod u_mod (
    .clk          (clk),
    .rst          (rst),
    .mix_valid    (mix_valid),
    .mix_ready    (mix_ready),
    .mix_data     (mix_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value)
  );

endmodule

`default_nettype wire

// File: hw/rtl/chrd_front.sv
`default_nettype none

module chrd_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [chrd_pkg::WORD_W-1:0]  start_seed,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [chrd_pkg::WORD_W-1:0]  modulus,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output chrd_pkg::qent_t                   push_data
);

  logic [chrd_pkg::WORD_W-1:0] counter;
  logic [chrd_pkg::WORD_W-1:0] counter_next;
  logic                        accept;

  assign cfg_ready  = 1'b1;
  assign in_stall   = !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = accept;

  always_comb begin
    push_data.draw    = counter;
    push_data.modulus = modulus;
  end

  always_comb begin
    counter_next = counter;
    if (cfg_valid && cfg_ready) begin
      counter_next = start_seed;
    end else if (accept) begin
      counter_next = counter + chrd_pkg::WORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= chrd_pkg::SEED_RESET;
    end else begin
      counter <= counter_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/chrd_queue.sv
`default_nettype none

module chrd_queue #(
  parameter int DEPTH = chrd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire chrd_pkg::qent_t  push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output chrd_pkg::qent_t       pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  chrd_pkg::qent_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/chrd_mix.sv
`default_nettype none

module chrd_mix (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire chrd_pkg::qent_t  q_data,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output chrd_pkg::draw_t       res_data
);

  localparam int W = chrd_pkg::WORD_W;
  localparam int H = chrd_pkg::HALF_W;

  chrd_pkg::mix_state_t state;
  chrd_pkg::mix_state_t state_next;
  chrd_pkg::prod_idx_t  idx;
  chrd_pkg::part_t      part;

  logic [W-1:0] lane_lo;
  logic [W-1:0] lane_mid;
  logic [W-1:0] lane_hi;
  logic [W-1:0] modulus;
  logic [W-1:0] pp;
  logic [W-1:0] prod;
  logic [W-1:0] w0;
  logic [W-1:0] w1;
  logic [W-1:0] w2;

  logic [W-1:0] lane_val;
  logic [W-1:0] c_val;
  logic [H-1:0] mul_a;
  logic [H-1:0] mul_b;
  logic [W-1:0] mul_p;
  logic         last_part;
  logic         last_prod;

  // operand selection for the shared 32x32 multiplier
  always_comb begin
    unique case (chrd_pkg::mul_lane(idx))
      chrd_pkg::LANE_LO:  lane_val = lane_lo;
      chrd_pkg::LANE_MID: lane_val = lane_mid;
      chrd_pkg::LANE_HI:  lane_val = lane_hi;
      default:            lane_val = lane_mid;
    endcase
    c_val = chrd_pkg::mul_const(idx);
    unique case (part)
      chrd_pkg::PART_LL: begin
        mul_a = lane_val[H-1:0];
        mul_b = c_val[H-1:0];
      end
      chrd_pkg::PART_HL: begin
        mul_a = lane_val[W-1:H];
        mul_b = c_val[H-1:0];
      end
      chrd_pkg::PART_LH: begin
        mul_a = lane_val[H-1:0];
        mul_b = c_val[W-1:H];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign last_part = (part == chrd_pkg::PART_LH);
  assign last_prod = (idx == chrd_pkg::PROD_IDX_W'(chrd_pkg::PRODUCTS - 1));

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      chrd_pkg::MX_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          state_next = chrd_pkg::MX_MUL;
        end
      end
      chrd_pkg::MX_MUL: state_next = chrd_pkg::MX_ACC;
      chrd_pkg::MX_ACC: begin
        state_next = last_part ? chrd_pkg::MX_ROUTE : chrd_pkg::MX_MUL;
      end
      chrd_pkg::MX_ROUTE: begin
        state_next = last_prod ? chrd_pkg::MX_FOLD_LO : chrd_pkg::MX_MUL;
      end
      chrd_pkg::MX_FOLD_LO: state_next = chrd_pkg::MX_FOLD_HI;
      chrd_pkg::MX_FOLD_HI: state_next = chrd_pkg::MX_DONE;
      chrd_pkg::MX_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = chrd_pkg::MX_IDLE;
        end
      end
      default: state_next = chrd_pkg::MX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chrd_pkg::MX_IDLE;
      idx   <= '0;
      part  <= chrd_pkg::PART_LL;
    end else begin
      state <= state_next;
      if (state == chrd_pkg::MX_IDLE) begin
        idx  <= '0;
        part <= chrd_pkg::PART_LL;
      end else if (state == chrd_pkg::MX_ACC) begin
        unique case (part)
          chrd_pkg::PART_LL: part <= chrd_pkg::PART_HL;
          chrd_pkg::PART_HL: part <= chrd_pkg::PART_LH;
          default:           part <= chrd_pkg::PART_LL;
        endcase
      end else if (state == chrd_pkg::MX_ROUTE) begin
        idx <= idx + chrd_pkg::PROD_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      chrd_pkg::MX_IDLE: begin
        if (q_valid) begin
          lane_lo  <= q_data.draw - chrd_pkg::LOW_OFFSET;
          lane_mid <= q_data.draw;
          lane_hi  <= q_data.draw + chrd_pkg::HIGH_OFFSET;
          modulus  <= q_data.modulus;
          prod     <= '0;
          w0       <= '0;
          w1       <= '0;
          w2       <= '0;
        end
      end
      chrd_pkg::MX_MUL: pp <= mul_p;
      chrd_pkg::MX_ACC: begin
        if (part == chrd_pkg::PART_LL) begin
          prod <= prod + pp;
        end else begin
          prod <= prod + {pp[H-1:0], {H{1'b0}}};
        end
      end
      chrd_pkg::MX_ROUTE: begin
        prod <= '0;
        unique case (chrd_pkg::mul_route(idx))
          chrd_pkg::RT_W0_W1: begin
            w0 <= w0 + {{H{1'b0}}, prod[W-1:H]};
            w1 <= w1 + prod;
          end
          chrd_pkg::RT_W0: w0 <= w0 + prod;
          chrd_pkg::RT_W1_W2: begin
            w1 <= w1 + {{H{1'b0}}, prod[W-1:H]};
            w2 <= prod + chrd_pkg::LOW_ADD;
          end
          default: ;
        endcase
      end
      chrd_pkg::MX_FOLD_LO: w1 <= w1 + {{H{1'b0}}, w2[W-1:H]};
      chrd_pkg::MX_FOLD_HI: w0 <= w0 + {{H{1'b0}}, w1[W-1:H]};
      default: ;
    endcase
  end

  always_comb begin
    res_data.value   = {w0[H-1:0], w1[H-1:0]};
    res_data.modulus = modulus;
  end

endmodule

`default_nettype wire

// File: hw/rtl/chrd_mod.sv
`default_nettype none

module chrd_mod (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         mix_valid,
  output logic                              mix_ready,
  input  wire chrd_pkg::draw_t              mix_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [chrd_pkg::WORD_W-1:0]       random_value
);

  localparam int W     = chrd_pkg::WORD_W;
  localparam int CNT_W = $clog2(W);

  chrd_pkg::mod_state_t state;
  chrd_pkg::mod_state_t state_next;

  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     dvd;
  logic [W-1:0]     divisor;
  logic [W-1:0]     rem;
  logic [W:0]       shifted;
  logic [W+1:0]     diff;
  logic             out_free;
  logic             load_out;

  // one quotient bit per cycle, restoring
  assign shifted  = {rem, dvd[W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, divisor};
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    mix_ready  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      chrd_pkg::MD_IDLE: begin
        mix_ready = 1'b1;
        if (mix_valid) begin
          state_next = (mix_data.modulus == '0) ? chrd_pkg::MD_FIN : chrd_pkg::MD_RUN;
        end
      end
      chrd_pkg::MD_RUN: begin
        if (cnt == CNT_W'(W - 1)) begin
          state_next = chrd_pkg::MD_FIN;
        end
      end
      chrd_pkg::MD_FIN: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = chrd_pkg::MD_IDLE;
        end
      end
      default: state_next = chrd_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= chrd_pkg::MD_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == chrd_pkg::MD_RUN) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == chrd_pkg::MD_IDLE && mix_valid) begin
      dvd     <= mix_data.value;
      divisor <= mix_data.modulus;
      rem     <= (mix_data.modulus == '0) ? mix_data.value : '0;
    end else if (state == chrd_pkg::MD_RUN) begin
      dvd <= {dvd[W-2:0], 1'b0};
      rem <= diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
    end
    if (load_out) begin
      random_value <= rem;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import chrd_pkg::*;

  // Draw test bench: a counter-driven hash generator with an optional modulo stage.
  // A local model tracks the draw counter and predicts each random_value. Results are
  // checked in order against a FIFO of expectations. Seed writes happen only when no
  // result is outstanding.

  // ---------------------------------------------------------------------------
  // DUT connections. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [WORD_W-1:0] start_seed = '0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [WORD_W-1:0] modulus    = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [WORD_W-1:0] random_value;

  counter_hash_random_draw_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .start_seed   (start_seed),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .modulus      (modulus),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Directed stimulus table. A row either reloads the seed or requests one draw.
  // The result is pinned only where it is obvious (modulus of one gives zero);
  // every other row goes through the local model.
  // ---------------------------------------------------------------------------
  typedef enum logic [0:0] {
    ROW_DRAW,
    ROW_SEED
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [WORD_W-1:0] value;   // modulus for a draw, seed for a reload
    logic              pinned;
    logic [WORD_W-1:0] result;
  } stim_row_t;

  typedef struct packed {
    logic              on;
    logic [WORD_W-1:0] value;
  } pinned_t;

  localparam int DIR_ROWS = 24;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // reset counter value, modulus extremes
    '{ROW_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0001, 1'b1, 64'h0},
    '{ROW_DRAW, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0002, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0003, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_ffff_ffff, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0001_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h7fff_ffff_ffff_ffff, 1'b0, 64'h0},
    // counter runs through all-ones and wraps to zero
    '{ROW_SEED, 64'hffff_ffff_ffff_fffe, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0001, 1'b1, 64'h0},
    // zero seed, alternating modulus patterns
    '{ROW_SEED, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
    // low lane crosses from all-ones to zero
    '{ROW_SEED, 64'h0000_0000_0bad_d0cf, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    // high lane crosses from all-ones to zero
    '{ROW_SEED, 64'hffff_ffff_f3ff_8252, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{ROW_DRAW, 64'hffff_ffff_ffff_fffe, 1'b0, 64'h0}
  };

  // ---------------------------------------------------------------------------
  // Local model state and expectation store
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] next_draw;          // counter value the next request will use
  logic [WORD_W-1:0] draw_expect_q [$];  // predicted random_value, oldest first
  pinned_t           pinned_q [$];       // per-request pinned result, in offer order
  int                n_accepted  = 0;
  int                mismatches  = 0;
  int                calm_left   = 0;    // remaining back-to-back requests in a burst

  // Three-lane mix of one counter value; all arithmetic wraps at 64 bits.
  function automatic logic [WORD_W-1:0] scramble_draw(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] lane_lo, lane_hi, w0, w1, w2;
    lane_lo = v - LOW_OFFSET;
    lane_hi = v + HIGH_OFFSET;
    w0 = ((v * LANE_C_MUL) >> 32) + ((lane_hi * LANE_B_MUL) >> 32)
       + (lane_lo * LANE_C_MUL) + (v * LANE_B_MUL) + (lane_hi * LANE_A_MUL);
    w1 = ((lane_hi * LANE_C_MUL) >> 32) + (v * LANE_C_MUL) + (lane_hi * LANE_B_MUL);
    w2 = (lane_hi * LANE_C_MUL) + LOW_ADD;
    // carry fold: low word into middle, middle into top
    w1 = w1 + (w2 >> 32);
    w0 = w0 + (w1 >> 32);
    return {w0[HALF_W-1:0], w1[HALF_W-1:0]};
  endfunction

  function automatic logic [WORD_W-1:0] bounded_draw(input logic [WORD_W-1:0] v,
                                                      input logic [WORD_W-1:0] m);
    return (m == '0) ? v : v % m;
  endfunction

  task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    $display("tb_top: mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Everything is sampled at the rising edge, before the DUT and the
  // drivers update, so a transfer is seen exactly as the DUT sees it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    pinned_t           pin;
    logic [WORD_W-1:0] want;
    if (rst) begin
      next_draw = SEED_RESET;
      draw_expect_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (draw_expect_q.size() == 0) begin
          note_mismatch("random_value with nothing pending", random_value, '0);
        end else begin
          want = draw_expect_q.pop_front();
          if (random_value !== want) note_mismatch("random_value", random_value, want);
        end
      end
      // seed write reloads the counter
      if (cfg_valid && cfg_ready) next_draw = start_seed;
      // request transfer: draw from the current counter, then bump it
      if (in_valid && !in_stall) begin
        pin  = pinned_q.pop_front();
        want = bounded_draw(scramble_draw(next_draw), modulus);
        next_draw = next_draw + 1'b1;
        draw_expect_q.push_back(pin.on ? pin.value : want);
        n_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until it transfers. Returns at the edge of the
  // transfer, with in_valid still high.
  task automatic offer_request(input logic [WORD_W-1:0] m, input logic pin_on,
                               input logic [WORD_W-1:0] pin_val);
    pinned_t p;
    p.on    = pin_on;
    p.value = pin_val;
    pinned_q.push_back(p);
    in_valid <= 1'b1;
    modulus  <= m;
    do @(posedge clk); while (in_stall);
  endtask

  // Gap before the next request: mostly none or short, a few long, plus bursts.
  function automatic int pick_send_gap();
    int pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 150);
  endfunction

  // Called at a transfer edge; a zero gap leaves in_valid high for the next offer.
  task automatic pace_sender();
    int gap;
    gap = pick_send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      modulus  <= {$urandom, $urandom};  // junk while idle
      repeat (gap) @(posedge clk);
    end
  endtask

  // Seed reload, only once every outstanding draw has come back.
  task automatic load_seed(input logic [WORD_W-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (draw_expect_q.size() != 0);
    start_seed <= v;
    cfg_valid  <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
  endtask

  // Modulus mix: zero, tiny, powers of two and neighbors, truncated widths,
  // values near all-ones, and full-width random.
  function automatic logic [WORD_W-1:0] pick_modulus();
    logic [WORD_W-1:0] full;
    int                pick, k;
    full = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, 63);
    if (pick < 20) return '0;
    if (pick < 35) return WORD_W'($urandom_range(1, 16));
    if (pick < 50) return 64'd1 << k;
    if (pick < 60) return $urandom_range(0, 1) ? (64'd1 << k) + 64'd1 : (64'd1 << k) - 64'd1;
    if (pick < 70) return full >> k;
    if (pick < 80) return 64'hffff_ffff_ffff_ffff - WORD_W'($urandom_range(0, 1000));
    return full;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then five random phases each opened
  // by a seed reload, then drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [WORD_W-1:0] seed_pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SEED) begin
        load_seed(dir_rows[i].value);
      end else begin
        offer_request(dir_rows[i].value, dir_rows[i].pinned, dir_rows[i].result);
        pace_sender();
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: seed_pick = 64'hffff_ffff_ffff_ffff - WORD_W'($urandom_range(0, 50)); // wraps
        2: seed_pick = WORD_W'($urandom_range(0, 50));                          // near zero
        4: seed_pick = 64'hffff_ffff_f3ff_8253 - WORD_W'($urandom_range(0, 50)); // high lane
        default: seed_pick = {$urandom, $urandom};
      endcase
      load_seed(seed_pick);
      repeat (100) begin
        offer_request(pick_modulus(), 1'b0, '0);
        pace_sender();
      end
    end

    // drain, then give the block time to show any stray result
    in_valid <= 1'b0;
    do @(posedge clk); while (draw_expect_q.size() != 0);
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side backpressure. One long hold-off lets the internal queue fill and
  // forces in_stall while requests keep coming; otherwise random stall patterns
  // with stall-free stretches.
  // ---------------------------------------------------------------------------
  initial begin : result_pacing
    int  n, pick;
    bit  held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (!held && n_accepted >= 60) begin
        held = 1'b1;
        out_stall <= 1'b1;
        n = 900;
      end else if (pick < 45) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 4);
      end else if (pick < 80) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else if (pick < 92) begin
        out_stall <= 1'b0;
        n = $urandom_range(20, 60);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(10, 80);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #15_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
